>>> sv/tdha_pkg.sv
// Shared types and codes for the top-down heap allocator with handle table.
// Used by the allocator top level and its port checker; no dependencies.
package tdha_pkg;

    // Fixed header in front of every block; handle entries are this far apart
    localparam int unsigned HdrBytes    = 8;
    localparam int unsigned EntryStride = 8;

    // Commands
    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_RESET  = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } t_status;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_LEGACY_MODE = 2'd0,
        CFG_TABLE_BASE  = 2'd1,
        CFG_PROGRAM_END = 2'd2,
        CFG_HEAP_END    = 2'd3
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FINISH
    } t_state;

    // Request payload
    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] request_size;
        logic [30:0] handle_in;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] handle_out;
        logic [30:0] block_addr;
        logic [24:0] block_size;
        logic [30:0] heap_top_out;
    } t_rsp;

    // One handle table entry: header location and block size
    typedef struct packed {
        logic [30:0] hdr;
        logic [24:0] size;
    } t_entry;

endpackage

>>> sv/top_down_heap_allocator_with_handles.sv
// Top-down heap allocator with a handle table kept in a synchronous memory.
// Depends on tdha_pkg for payload structs, codes and the sequencer states.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (t_req)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (t_rsp)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request at a time. Reset and unused commands, failed allocations, bad-handle
// frees and legacy allocations go from idle straight to the finish state; other frees
// pass through a table read state first, and handle allocations through the scan
// state, which walks the used bits one entry a cycle, up to TABLE_ENTRIES entries.
// The table memory has one write port and one registered read port.
// The result register frees the input side while a result waits to be taken.
// Reset (synchronous, active low) clears the used bits and loads heap top with 0;
// the table memory needs no clearing, every read is guarded by its used bit.
// A stalled output holds the sequencer in its final state until the slot frees.
module top_down_heap_allocator_with_handles
    import tdha_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);

    localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [30:0] TblSpan  = 31'(EntryStride * TABLE_ENTRIES);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

    // Configuration registers
    logic        r_legacy_mode;
    logic [30:0] r_table_base;
    logic [30:0] r_program_end;
    logic [30:0] r_heap_end;

    // Allocator state
    t_state              r_state, n_state;
    logic [30:0]         r_heap_top;
    logic [TABLE_ENTRIES-1:0] r_used;
    logic [IdxW-1:0]     r_scan;
    logic [IdxW-1:0]     r_idx;
    logic [30:0]         r_loc;
    logic [24:0]         r_size;
    t_rsp                r_res, n_res;
    logic                r_out_valid;
    t_rsp                r_out_data;

    // Table memory
    t_entry              r_mem [TABLE_ENTRIES];
    t_entry              r_rd;

    // Control decodes
    logic w_in_fire, w_out_load, w_mem_we, w_mem_re, w_cfg_fire;

    // Allocation arithmetic on the incoming request
    logic [24:0]     w_size;
    logic [30:0]     w_loc;
    logic            w_nofit;
    logic [30:0]     w_diff;
    logic            w_bad;
    logic [IdxW-1:0] w_free_idx;
    logic            w_slot_free;
    logic [30:0]     w_free_hdr;

    assign w_size  = ((25'(i_in_data.request_size) + 25'd3) & ~25'd3) + 25'(HdrBytes);
    assign w_loc   = r_heap_top - 31'(w_size);
    assign w_nofit = (r_heap_top < 31'(w_size)) || (w_loc <= r_program_end);

    // Handle decode for free
    assign w_diff     = i_in_data.handle_in - r_table_base;
    assign w_bad      = (w_diff[2:0] != 3'd0) || (w_diff >= TblSpan);
    assign w_free_idx = w_diff[IdxW+2:3];

    assign w_slot_free = !r_used[r_scan];
    assign w_free_hdr  = r_rd.hdr;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    priority if (i_in_data.cmd == CMD_ALLOC && !w_nofit && !r_legacy_mode)
                        n_state = S_SCAN;
                    else if (i_in_data.cmd == CMD_FREE && !w_bad)
                        n_state = S_FREE_RD;
                    else
                        n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                if (w_slot_free || r_scan == LastIdx) n_state = S_FINISH;
            end
            S_FREE_RD: n_state = S_FINISH;
            S_FINISH: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_cfg_ready = 1'b1;
        w_in_fire   = i_in_valid && (r_state == S_IDLE);
        w_cfg_fire  = i_cfg_valid;
        w_out_load  = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
        w_mem_we    = (r_state == S_SCAN) && w_slot_free;
        w_mem_re    = w_in_fire && (i_in_data.cmd == CMD_FREE) && !w_bad;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_legacy_mode <= 1'b0;
            r_table_base  <= '0;
            r_program_end <= '0;
            r_heap_end    <= '0;
        end else if (w_cfg_fire) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LEGACY_MODE: r_legacy_mode <= i_cfg_data[0];
                CFG_TABLE_BASE:  r_table_base  <= i_cfg_data;
                CFG_PROGRAM_END: r_program_end <= i_cfg_data;
                CFG_HEAP_END:    r_heap_end    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Table memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[r_scan] <= '{hdr: r_loc, size: r_size};
        if (w_mem_re) r_rd <= r_mem[w_free_idx];
    end

    // Sequencer state, heap top and used bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_heap_top <= '0;
            r_used     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        unique case (t_cmd'(i_in_data.cmd))
                            CMD_ALLOC: if (!w_nofit) r_heap_top <= w_loc;
                            CMD_RESET: begin
                                r_heap_top <= r_heap_end;
                                r_used     <= '0;
                            end
                            CMD_FREE, CMD_UNUSED: ;
                            default: ;
                        endcase
                    end
                end
                S_SCAN: if (w_slot_free) r_used[r_scan] <= 1'b1;
                S_FREE_RD: begin
                    if (r_used[r_idx]) begin
                        r_used[r_idx] <= 1'b0;
                        if (r_heap_top == w_free_hdr)
                            r_heap_top <= 31'(r_heap_top + 31'(r_rd.size));
                    end
                end
                S_FINISH: ;
                default: ;
            endcase
        end
    end

    // Result assembly
    always_comb begin
        n_res = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_res = '{status: ST_OK, default: '0};
                    unique case (t_cmd'(i_in_data.cmd))
                        CMD_ALLOC: begin
                            n_res.block_size = w_size;
                            if (w_nofit) begin
                                n_res.status = ST_NO_SPACE;
                            end else begin
                                n_res.block_addr = w_loc;
                                if (r_legacy_mode) n_res.handle_out = w_loc;
                            end
                        end
                        CMD_FREE: if (w_bad) n_res.status = ST_BAD_HANDLE;
                        CMD_RESET, CMD_UNUSED: ;
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_slot_free) begin
                    n_res.handle_out = 31'(r_table_base + (31'(r_scan) << 3));
                end else if (r_scan == LastIdx) begin
                    n_res.status = ST_TABLE_FULL;
                end
            end
            S_FREE_RD: begin
                if (r_used[r_idx]) begin
                    n_res.block_addr = w_free_hdr;
                    n_res.block_size = r_rd.size;
                end
            end
            S_FINISH: ;
            default: ;
        endcase
    end

    // Request payload and result register
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    r_loc  <= w_loc;
                    r_size <= w_size;
                    r_scan <= '0;
                    r_idx  <= w_free_idx;
                end
            end
            S_SCAN: begin
                if (!w_slot_free && r_scan != LastIdx) r_scan <= r_scan + 1'b1;
            end
            S_FREE_RD: ;
            S_FINISH: ;
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= '{status:       r_res.status,
                            handle_out:   r_res.handle_out,
                            block_addr:   r_res.block_addr,
                            block_size:   r_res.block_size,
                            heap_top_out: r_heap_top};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> sv/tdha_chk.sv
// Port-level checker for the heap allocator, bound to the top level.
// Depends on tdha_pkg for the payload structs and status codes.
module tdha_chk
    import tdha_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_req        i_in_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_rsp        o_out_data,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [30:0] i_cfg_data
);

    // A result waiting for transfer stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed before transfer");

    // One request in flight: input closes right after a transfer
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted a second request while busy");

    // Failed allocation reports no handle and no block location
    a_no_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_NO_SPACE
        |-> o_out_data.handle_out == 31'd0 && o_out_data.block_addr == 31'd0)
        else $error("no-space result carries an address");

    // Full table keeps the space: block sits at the new heap top
    a_table_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_TABLE_FULL
        |-> o_out_data.handle_out == 31'd0
            && o_out_data.block_addr == o_out_data.heap_top_out)
        else $error("table-full result inconsistent with heap top");

    // Bad handle touches nothing
    a_bad_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_BAD_HANDLE
        |-> o_out_data.block_size == 25'd0 && o_out_data.block_addr == 31'd0)
        else $error("bad-handle result reports a block");

endmodule

bind top_down_heap_allocator_with_handles tdha_chk u_tdha_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);
